[design/rct_pkg.sv]
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants of the range code table
// sizes of the code store and the slot map, controller codes and the
// command and status words between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

   localparam int MAP_ENTRIES = 16;
   localparam int CODE_SLOTS  = 8;

   localparam int TEMP_W     = 8;
   localparam int CODE_W     = 40;
   localparam int SLOT_W     = $clog2(CODE_SLOTS + 1);
   localparam int SLOT_IDX_W = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
   localparam int MAP_IDX_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   localparam logic [0:0]        REQ_ADD    = 1'b0;
   localparam logic [0:0]        REQ_LOOKUP = 1'b1;
   localparam logic [SLOT_W-1:0] SLOT_NONE  = SLOT_W'(CODE_SLOTS);

   // kind of result word to build
   typedef enum logic [1:0] {
      RK_LOOKUP    = 2'd0,
      RK_FULL      = 2'd1,
      RK_RANGE_BAD = 2'd2,
      RK_ADD_OK    = 2'd3
   } rsp_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SEARCH  = 5'b00010,
      ST_FILL    = 5'b00100,
      ST_LMAP    = 5'b01000,
      ST_RESPOND = 5'b10000
   } ctrl_state_type;

   typedef struct packed {
      logic         load;
      logic         search;
      logic         fill;
      logic         map_read;
      logic         respond;
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic search_hit;
      logic search_last;
      logic range_ok;
      logic range_empty;
      logic fill_last;
   } dp_status_type;

endpackage

`default_nettype wire

[design/rct_ctrl.sv]
// ----------------------------------------------------------------------------
// rct_ctrl: sequencer of the range code table
// steps an add through the store search and the map fill, a lookup through
// the map read, and issues the result word
// ----------------------------------------------------------------------------
`default_nettype none

module rct_ctrl
   import rct_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   rsp_kind_type   kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RK_LOOKUP;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.kind     = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.is_lookup) begin
               // a lookup word reads the map in this cycle instead
               kind_in  = RK_LOOKUP;
               state_in = ST_RESPOND;
            end else if (status.search_hit) begin
               if (!status.range_ok) begin
                  kind_in  = RK_RANGE_BAD;
                  state_in = ST_RESPOND;
               end else if (status.range_empty) begin
                  kind_in  = RK_ADD_OK;
                  state_in = ST_RESPOND;
               end else begin
                  state_in = ST_FILL;
               end
            end else if (status.search_last) begin
               kind_in  = RK_FULL;
               state_in = ST_RESPOND;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.fill_last) begin
               kind_in  = RK_ADD_OK;
               state_in = ST_RESPOND;
            end
         end
         ST_LMAP: begin
            cmd.map_read = 1'b1;
            kind_in      = RK_LOOKUP;
            state_in     = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // the request type is only known once the word is loaded
      if (state_ff == ST_IDLE && start) begin
         state_in = ST_SEARCH;
      end
   end

   // lookups branch after the load cycle
   logic lookup_pending_ff, lookup_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_pending_ff <= 1'b0;
      end else begin
         lookup_pending_ff <= lookup_pending_in;
      end
   end

   assign lookup_pending_in = 1'b0;
   assign busy = (state_ff != ST_IDLE) || lookup_pending_ff;

endmodule

`default_nettype wire

[design/rct_datapath.sv]
// ----------------------------------------------------------------------------
// rct_datapath: code store, slot map and result registers
// holds the base temperature, the request word, the search and fill
// counters and the one-cycle result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module rct_datapath
   import rct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_status_type          status,
   input  wire logic              csr_valid,
   input  wire logic [TEMP_W-1:0] csr_data,
   input  wire logic              req_type,
   input  wire logic [TEMP_W-1:0] req_range_start,
   input  wire logic [TEMP_W-1:0] req_range_end,
   input  wire logic [CODE_W-1:0] req_code_value,
   input  wire logic [TEMP_W-1:0] req_query_temp,
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_hit,
   output logic [CODE_W-1:0]      rsp_code_out
);

   logic [TEMP_W-1:0]     base_ff;
   logic                  lookup_ff;
   logic [CODE_W-1:0]     code_ff;
   logic [TEMP_W-1:0]     end_ff;
   logic [TEMP_W-1:0]     temp_ff;
   logic                  range_ok_ff, range_empty_ff, temp_ok_ff;
   logic [SLOT_IDX_W-1:0] idx_ff;
   logic [MAP_IDX_W-1:0]  fidx_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     map_rd_ff;
   logic [SLOT_W-1:0]     map_ff [MAP_ENTRIES];
   logic [CODE_W-1:0]     store_ff [CODE_SLOTS];

   logic                  rsp_valid_ff, rsp_ok_ff, rsp_hit_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [CODE_W-1:0]     rsp_code_ff;

   logic [TEMP_W-1:0]     b_off, e_off, t_off;
   logic                  b_in_map, e_in_map;
   logic [SLOT_IDX_W-1:0] rd_addr;
   logic [CODE_W-1:0]     rd_code;
   logic                  match;
   logic                  lookup_hit;

   // bound offsets with 8-bit wrap
   assign b_off    = req_range_start - base_ff;
   assign e_off    = req_range_end - base_ff;
   assign t_off    = req_query_temp - base_ff;
   assign b_in_map = {1'b0, b_off} < (TEMP_W + 1)'(MAP_ENTRIES);
   assign e_in_map = {1'b0, e_off} < (TEMP_W + 1)'(MAP_ENTRIES);

   // single store read port: search slot or mapped slot
   assign rd_addr = cmd.search ? idx_ff : map_rd_ff[SLOT_IDX_W-1:0];
   assign rd_code = store_ff[rd_addr];
   assign match   = (rd_code == code_ff) || (rd_code == '0);

   assign lookup_hit = temp_ok_ff && (map_rd_ff < SLOT_NONE) && (rd_code != '0);

   assign status.is_lookup   = lookup_ff;
   assign status.search_hit  = match;
   assign status.search_last = (idx_ff == SLOT_IDX_W'(CODE_SLOTS - 1));
   assign status.range_ok    = range_ok_ff;
   assign status.range_empty = range_empty_ff;
   assign status.fill_last   = (fidx_ff == end_ff[MAP_IDX_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= TEMP_W'(16);
      end else if (csr_valid) begin
         base_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lookup_ff      <= req_type;
         code_ff        <= req_code_value;
         end_ff         <= e_off;
         temp_ff        <= t_off;
         range_ok_ff    <= b_in_map && e_in_map;
         range_empty_ff <= b_off > e_off;
         temp_ok_ff     <= {1'b0, t_off} < (TEMP_W + 1)'(MAP_ENTRIES);
         idx_ff         <= '0;
         fidx_ff        <= b_off[MAP_IDX_W-1:0];
      end
      if (cmd.search && !match) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.search && match) begin
         slot_ff <= SLOT_W'(idx_ff);
      end
      if (cmd.fill) begin
         fidx_ff <= fidx_ff + 1'b1;
      end
      if (cmd.map_read) begin
         map_rd_ff <= map_ff[temp_ff[MAP_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_ENTRIES; i++) begin
            map_ff[i] <= SLOT_NONE;
         end
         for (int i = 0; i < CODE_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (cmd.fill) begin
            map_ff[fidx_ff] <= slot_ff;
         end
         if (cmd.search && match) begin
            store_ff[idx_ff] <= code_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ok_ff <= (cmd.kind == RK_ADD_OK);
         case (cmd.kind)
            RK_LOOKUP: begin
               rsp_slot_ff <= SLOT_NONE;
               rsp_hit_ff  <= lookup_hit;
               rsp_code_ff <= lookup_hit ? rd_code : '0;
            end
            RK_FULL: begin
               rsp_slot_ff <= SLOT_NONE;
               rsp_hit_ff  <= 1'b0;
               rsp_code_ff <= '0;
            end
            default: begin
               rsp_slot_ff <= slot_ff;
               rsp_hit_ff  <= 1'b0;
               rsp_code_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_code_out = rsp_code_ff;

endmodule

`default_nettype wire

[design/rct_route.sv]
// ----------------------------------------------------------------------------
// rct_route: command steering after the load cycle
// sends a loaded lookup to the map read instead of the store search
// ----------------------------------------------------------------------------
`default_nettype none

module rct_route
   import rct_pkg::*;
(
   input  wire dp_cmd_type    cmd_raw,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   // a search cycle of a lookup word becomes its map read
   always_comb begin
      cmd = cmd_raw;
      if (cmd_raw.search && status.is_lookup) begin
         cmd.search   = 1'b0;
         cmd.map_read = 1'b1;
      end
   end

endmodule

`default_nettype wire

[design/range_code_table_core.sv]
// ----------------------------------------------------------------------------
// range_code_table_core: deduplicated code store with temperature slot map
// an add runs the store search, one slot a cycle, then the map fill, one entry
//   a cycle, so its time grows with slots searched and entries filled; a lookup
//   reads the map in place of the search
// throughput: one word at a time; start is taken again once busy drops,
//   which is the cycle that carries the result strobe
// reset: synchronous, clears store and map and loads base temperature 16
// the receiver cannot stall: each result word is shown for one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module range_code_table_core
   import rct_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request word
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_type,
   input  wire logic [TEMP_W-1:0] req_range_start,
   input  wire logic [TEMP_W-1:0] req_range_end,
   input  wire logic [CODE_W-1:0] req_code_value,
   input  wire logic [TEMP_W-1:0] req_query_temp,
   // result word
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_hit,
   output logic [CODE_W-1:0]      rsp_code_out,
   // base temperature register
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [TEMP_W-1:0] csr_data
);

   dp_cmd_type    cmd_raw;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          accept;

   // register writes must arrive only while idle; the block does not enforce it and is always ready
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // sequencer: idle, store search, map fill, map read, result
   rct_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .busy   (busy),
      .cmd    (cmd_raw),
      .status (status)
   );

   // lookups skip the search and read the map in its place
   rct_route u_route (
      .cmd_raw (cmd_raw),
      .status  (status),
      .cmd     (cmd)
   );

   // store, map, counters and result registers
   rct_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .req_type        (req_type),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_code_value  (req_code_value),
      .req_query_temp  (req_query_temp),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_slot        (rsp_slot),
      .rsp_hit         (rsp_hit),
      .rsp_code_out    (rsp_code_out)
   );

   // an accepted word always makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   // a result strobe only follows a busy cycle and frees the request side
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe outside a finished word");

   // a successful add names a real slot
   a_ok_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_slot < SLOT_NONE))
      else $error("successful add without a slot");

   // a miss carries the empty code; the check that hit and ok are never together only runs on a miss
   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_code_out == '0) && !(rsp_hit && rsp_ok))
      else $error("result word mixes add and lookup fields");

endmodule

`default_nettype wire
